// File: hdl/srctok_pkg.sv
`timescale 1ns / 1ps

package srctok_pkg;

    // default widths of positions (line, column, length) and byte offset
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int OFFSET_WIDTH_DEF   = 32;

    // token buffer: one beat out per cycle while the output is not stalled, up to three tokens per byte
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_WIDTH  = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ASSIGN     = 8'h3D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_ASSIGN = 3'd2,
        KIND_PLUS   = 3'd3,
        KIND_STAR   = 3'd4,
        KIND_SEMI   = 3'd5,
        KIND_END    = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } mode_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDERSCORE});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

endpackage

// File: hdl/source_tokenizer.sv
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// source in | src_valid / src_stall  | source_char, final_char
// tokens out| tok_valid / tok_stall  | token_kind, token_line, token_column,
//           |                        | token_offset, token_length, last_of_run
//
// one source beat is taken per cycle while src_stall is low; a byte yields zero
// to three tokens, and the token buffer hands out one token beat per cycle while
// tok_stall is low, so the byte rate drops only while tokens back up in the buffer
// scanner state updates in the same cycle a byte is taken; a byte's tokens are
// registered into the token buffer and reach the output ports from its head
// src_stall rises when two or more tokens wait in the four-entry buffer
// reset clears the scanner to line 1, column 1, offset 0 and empties the buffer

module source_tokenizer
    import srctok_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int OFFSET_WIDTH   = OFFSET_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      src_valid,
    output logic                      src_stall,
    input  logic [7:0]                source_char,
    input  logic                      final_char,

    output logic                      tok_valid,
    input  logic                      tok_stall,
    output logic [2:0]                token_kind,
    output logic [POSITION_WIDTH-1:0] token_line,
    output logic [POSITION_WIDTH-1:0] token_column,
    output logic [OFFSET_WIDTH-1:0]   token_offset,
    output logic [POSITION_WIDTH-1:0] token_length,
    output logic                      last_of_run
);

    localparam logic [POSITION_WIDTH-1:0] POS_ONE  = POSITION_WIDTH'(1);
    localparam logic [POSITION_WIDTH-1:0] POS_ZERO = '0;
    localparam logic [OFFSET_WIDTH-1:0]   OFF_ZERO = '0;

    typedef struct packed {
        kind_t                     kind;
        logic [POSITION_WIDTH-1:0] line;
        logic [POSITION_WIDTH-1:0] column;
        logic [OFFSET_WIDTH-1:0]   offset;
        logic [POSITION_WIDTH-1:0] length;
        logic                      last;
    } token_t;

    function automatic logic [POSITION_WIDTH-1:0] sat_inc(
        input logic [POSITION_WIDTH-1:0] v
    );
        return (&v) ? v : v + POS_ONE;
    endfunction

    // scanner state
    mode_t                     mode_reg, mode_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [POSITION_WIDTH-1:0] col_reg, col_next;
    logic [OFFSET_WIDTH-1:0]   pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0] open_line_reg, open_line_next;
    logic [POSITION_WIDTH-1:0] open_col_reg, open_col_next;
    logic [OFFSET_WIDTH-1:0]   open_off_reg, open_off_next;
    logic [POSITION_WIDTH-1:0] open_len_reg, open_len_next;

    // token buffer, entry 0 is the head
    token_t                    q_reg [QUEUE_DEPTH];
    token_t                    q_next [QUEUE_DEPTH];
    logic [QCNT_WIDTH-1:0]     cnt_reg, cnt_next;

    logic                      push;
    logic                      pop;

    // candidate tokens of one byte, in emit order:
    // close old token, single-char token, close at end of source, end token
    token_t                    cand [4];
    logic                      cand_v [4];

    assign tok_valid = (cnt_reg != '0);
    assign src_stall = (cnt_reg > QCNT_WIDTH'(1));
    assign push      = src_valid && !src_stall;
    assign pop       = tok_valid && !tok_stall;

    assign token_kind   = q_reg[0].kind;
    assign token_line   = q_reg[0].line;
    assign token_column = q_reg[0].column;
    assign token_offset = q_reg[0].offset;
    assign token_length = q_reg[0].length;
    assign last_of_run  = q_reg[0].last;

    // scanner step
    always_comb
    begin
        logic                      letter;
        logic                      digit;
        logic                      extended;
        logic                      single;
        kind_t                     single_kind;
        mode_t                     mid_mode;
        logic [POSITION_WIDTH-1:0] mid_line;
        logic [POSITION_WIDTH-1:0] mid_col;
        logic [OFFSET_WIDTH-1:0]   mid_off;
        logic [POSITION_WIDTH-1:0] mid_len;
        logic [POSITION_WIDTH-1:0] adv_line;
        logic [POSITION_WIDTH-1:0] adv_col;
        logic [OFFSET_WIDTH-1:0]   adv_pos;

        letter = is_letter(source_char);
        digit  = is_digit(source_char);

        case (mode_reg)
            MODE_IDENT:  extended = letter || digit;
            MODE_NUMBER: extended = digit;
            default:     extended = 1'b0;
        endcase

        // closing the open token
        cand_v[0]      = !extended && (mode_reg == MODE_IDENT || mode_reg == MODE_NUMBER);
        cand[0].kind   = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        cand[0].line   = open_line_reg;
        cand[0].column = open_col_reg;
        cand[0].offset = open_off_reg;
        cand[0].length = open_len_reg;
        cand[0].last   = 1'b0;

        mid_mode = mode_reg;
        mid_line = open_line_reg;
        mid_col  = open_col_reg;
        mid_off  = open_off_reg;
        mid_len  = open_len_reg;
        if (extended)
        begin
            mid_len = sat_inc(open_len_reg);
        end
        else if (letter || digit)
        begin
            mid_mode = digit ? MODE_NUMBER : MODE_IDENT;
            mid_line = line_reg;
            mid_col  = col_reg;
            mid_off  = pos_reg;
            mid_len  = POS_ONE;
        end
        else
        begin
            mid_mode = MODE_IDLE;
        end

        // single-character tokens
        single      = 1'b1;
        single_kind = KIND_ASSIGN;
        case (source_char)
            CH_ASSIGN: single_kind = KIND_ASSIGN;
            CH_PLUS:   single_kind = KIND_PLUS;
            CH_STAR:   single_kind = KIND_STAR;
            CH_SEMI:   single_kind = KIND_SEMI;
            default:   single      = 1'b0;
        endcase

        cand_v[1]      = !extended && single;
        cand[1].kind   = single_kind;
        cand[1].line   = line_reg;
        cand[1].column = col_reg;
        cand[1].offset = pos_reg;
        cand[1].length = POS_ONE;
        cand[1].last   = 1'b0;

        // position advance
        if (source_char == CH_NEWLINE)
        begin
            adv_line = sat_inc(line_reg);
            adv_col  = POS_ONE;
        end
        else
        begin
            adv_line = line_reg;
            adv_col  = sat_inc(col_reg);
        end
        adv_pos = pos_reg + OFFSET_WIDTH'(1);

        // end of source: flush the open token, then the end marker
        cand_v[2]      = final_char && (mid_mode == MODE_IDENT || mid_mode == MODE_NUMBER);
        cand[2].kind   = (mid_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        cand[2].line   = mid_line;
        cand[2].column = mid_col;
        cand[2].offset = mid_off;
        cand[2].length = mid_len;
        cand[2].last   = 1'b0;

        cand_v[3]      = final_char;
        cand[3].kind   = KIND_END;
        cand[3].line   = adv_line;
        cand[3].column = adv_col;
        cand[3].offset = adv_pos;
        cand[3].length = POS_ZERO;
        cand[3].last   = 1'b1;

        // last beat of the run when nothing follows
        cand[0].last = !cand_v[1] && !final_char;
        cand[1].last = !final_char;

        if (final_char)
        begin
            mode_next      = MODE_IDLE;
            line_next      = POS_ONE;
            col_next       = POS_ONE;
            pos_next       = OFF_ZERO;
            open_line_next = POS_ONE;
            open_col_next  = POS_ONE;
            open_off_next  = OFF_ZERO;
            open_len_next  = POS_ZERO;
        end
        else
        begin
            mode_next      = mid_mode;
            line_next      = adv_line;
            col_next       = adv_col;
            pos_next       = adv_pos;
            open_line_next = mid_line;
            open_col_next  = mid_col;
            open_off_next  = mid_off;
            open_len_next  = mid_len;
        end
    end

    // token buffer: pop head, then append this byte's tokens in order
    always_comb
    begin
        logic [QCNT_WIDTH-1:0] idx;

        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
        end

        idx = cnt_reg - (pop ? QCNT_WIDTH'(1) : QCNT_WIDTH'(0));
        if (push)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (cand_v[j])
                begin
                    q_next[idx[QIDX_WIDTH-1:0]] = cand[j];
                    idx = idx + QCNT_WIDTH'(1);
                end
            end
        end
        cnt_next = idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            line_reg      <= POS_ONE;
            col_reg       <= POS_ONE;
            pos_reg       <= OFF_ZERO;
            open_line_reg <= POS_ONE;
            open_col_reg  <= POS_ONE;
            open_off_reg  <= OFF_ZERO;
            open_len_reg  <= POS_ZERO;
            cnt_reg       <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                mode_reg      <= mode_next;
                line_reg      <= line_next;
                col_reg       <= col_next;
                pos_reg       <= pos_next;
                open_line_reg <= open_line_next;
                open_col_reg  <= open_col_next;
                open_off_reg  <= open_off_next;
                open_len_reg  <= open_len_next;
            end
        end
    end

    // buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule
